>>> rtl/core/flconv_pkg.sv
// flconv_pkg: shared types and constants for the full linear convolution block
// no dependencies
`timescale 1ns / 1ps

package flconv_pkg;

   localparam int TAPS        = 4;
   localparam int SAMPLE_W    = 64;
   localparam int HALF_W      = SAMPLE_W / 2;
   localparam int ACC_W       = 2 * SAMPLE_W;
   localparam int TAP_W       = $clog2(TAPS + 1);
   localparam int WIN_D       = (TAPS > 1) ? TAPS - 1 : 1;
   localparam int HIST_IDX_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int TAP_COUNT_W = 3;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 64;

   localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 3'd4;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TAP_COUNT = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_0    = 8'd1;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                last_sample;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sum_hi;
      logic [SAMPLE_W-1:0] sum_lo;
      logic                last_result;
   } rsp_type;

   // transaction travelling along the row of cells
   typedef struct packed {
      logic                          last;
      logic [ACC_W-1:0]              acc;
      logic [TAPS-1:0][SAMPLE_W-1:0] ops;
   } tok_type;

endpackage

>>> rtl/core/flconv_seq.sv
// flconv_seq: sample window and flush sequencer feeding the cell row
// depends on flconv_pkg
`timescale 1ns / 1ps

module flconv_seq import flconv_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [TAP_W-1:0] eff_tc,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             tok_valid,
   input  logic             tok_ready,
   output tok_type          tok
);

   logic [WIN_D-1:0][SAMPLE_W-1:0] win_ff, win_in;
   logic                           flush_ff, flush_in;
   logic [TAP_W-1:0]               remain_ff, remain_in;

   logic [TAPS-1:0][SAMPLE_W-1:0]  hist;
   logic [SAMPLE_W-1:0]            cur_x;
   logic [TAP_W-1:0]               sel;
   logic                           fire;
   logic                           single;

   assign single    = (eff_tc == TAP_W'(1));
   assign cur_x     = flush_ff ? '0 : req_data.sample;
   assign tok_valid = flush_ff | req_valid;
   assign req_ready = ~flush_ff & tok_ready;
   assign fire      = tok_valid & tok_ready;

   always_comb begin
      hist[0] = cur_x;
      for (int i = 1; i < TAPS; i++) begin
         hist[i] = win_ff[i-1];
      end
      tok.acc  = '0;
      tok.last = flush_ff ? (remain_ff == TAP_W'(1)) : (req_data.last_sample & single);
      sel      = '0;
      // coefficient k meets the sample tc-1-k steps back
      for (int k = 0; k < TAPS; k++) begin
         sel = eff_tc - TAP_W'(1) - TAP_W'(k);
         if (TAP_W'(k) < eff_tc) begin
            tok.ops[k] = hist[sel[HIST_IDX_W-1:0]];
         end else begin
            tok.ops[k] = '0;
         end
      end
   end

   always_comb begin
      win_in    = win_ff;
      flush_in  = flush_ff;
      remain_in = remain_ff;
      if (fire) begin
         if (tok.last) begin
            win_in = '0;
         end else begin
            win_in[0] = cur_x;
            for (int i = 1; i < WIN_D; i++) begin
               win_in[i] = win_ff[i-1];
            end
         end
         if (flush_ff) begin
            remain_in = remain_ff - TAP_W'(1);
            if (remain_ff == TAP_W'(1)) begin
               flush_in = 1'b0;
            end
         end else if (req_data.last_sample && !single) begin
            flush_in  = 1'b1;
            remain_in = eff_tc - TAP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff    <= '0;
         flush_ff  <= 1'b0;
         remain_ff <= '0;
      end else begin
         win_ff    <= win_in;
         flush_ff  <= flush_in;
         remain_ff <= remain_in;
      end
   end

endmodule

>>> rtl/core/flconv_cell.sv
// flconv_cell: one tap of the row, split multiply then accumulate
// depends on flconv_pkg
`timescale 1ns / 1ps

module flconv_cell import flconv_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [SAMPLE_W-1:0] coef,
   input  logic                in_valid,
   output logic                in_ready,
   input  tok_type             in_tok,
   output logic                out_valid,
   input  logic                out_ready,
   output tok_type             out_tok
);

   logic                  a_valid_ff;
   tok_type               a_tok_ff, a_tok_in;
   logic [SAMPLE_W-1:0]   pp_ll_ff, pp_lh_ff, pp_hl_ff, pp_hh_ff;
   logic [SAMPLE_W-1:0]   pp_ll_in, pp_lh_in, pp_hl_in, pp_hh_in;
   logic                  b_valid_ff;
   tok_type               b_tok_ff, b_tok_in;
   logic                  a_ready, b_ready;
   logic [HALF_W-1:0]     x_lo, x_hi, c_lo, c_hi;

   assign b_ready  = ~b_valid_ff | out_ready;
   assign a_ready  = ~a_valid_ff | b_ready;
   assign in_ready = a_ready;

   assign x_lo = in_tok.ops[0][HALF_W-1:0];
   assign x_hi = in_tok.ops[0][SAMPLE_W-1:HALF_W];
   assign c_lo = coef[HALF_W-1:0];
   assign c_hi = coef[SAMPLE_W-1:HALF_W];

   // four 32x32 partial products
   assign pp_ll_in = x_lo * c_lo;
   assign pp_lh_in = x_lo * c_hi;
   assign pp_hl_in = x_hi * c_lo;
   assign pp_hh_in = x_hi * c_hi;

   always_comb begin
      a_tok_in.last = in_tok.last;
      a_tok_in.acc  = in_tok.acc;
      a_tok_in.ops  = in_tok.ops >> SAMPLE_W;
   end

   always_comb begin
      b_tok_in.last = a_tok_ff.last;
      b_tok_in.ops  = a_tok_ff.ops;
      b_tok_in.acc  = a_tok_ff.acc + {pp_hh_ff, pp_ll_ff}
                    + (ACC_W'(pp_lh_ff) << HALF_W)
                    + (ACC_W'(pp_hl_ff) << HALF_W);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= in_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_tok_ff <= a_tok_in;
         pp_ll_ff <= pp_ll_in;
         pp_lh_ff <= pp_lh_in;
         pp_hl_ff <= pp_hl_in;
         pp_hh_ff <= pp_hh_in;
      end
      if (b_ready && a_valid_ff) begin
         b_tok_ff <= b_tok_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_tok   = b_tok_ff;

endmodule

>>> rtl/core/full_linear_convolution_128.sv
// full_linear_convolution_128: top level, configuration registers and cell row
// depends on flconv_pkg, flconv_seq, flconv_cell
//
// channel   direction  payload                            transaction when
// req_      in         req_type  sample, last_sample      req_valid && req_ready
// rsp_      out        rsp_type  sum_hi, sum_lo, last     rsp_valid && rsp_ready
// csr_      in         csr_index, csr_data                csr_valid (always ready)
//
// one sample per cycle while the row is not stalled; a last sample, with more
// than one tap in use, holds req_ready low while the sequencer shifts zeros
// through the window; each cell has a multiply stage and an accumulate stage
// each stage holds its transaction while the next is full, so bubbles close up
// under rsp_ready stalls and the row takes samples until every stage is full
// synchronous reset clears the window, the flush state and the valid bits
`timescale 1ns / 1ps

module full_linear_convolution_128 import flconv_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic [TAP_COUNT_W-1:0]        tap_count_ff;
   logic [TAPS-1:0][SAMPLE_W-1:0] coef_ff;
   logic [TAP_W-1:0]              eff_tc;

   logic    [TAPS:0] chain_valid;
   logic    [TAPS:0] chain_ready;
   tok_type          chain_tok [TAPS+1];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TAP_COUNT_RESET;
         coef_ff      <= '0;
      end else if (csr_valid) begin
         if (csr_index == CSR_TAP_COUNT) begin
            tap_count_ff <= csr_data[TAP_COUNT_W-1:0];
         end
         for (int k = 0; k < TAPS; k++) begin
            if (csr_index == CSR_COEF_0 + CSR_INDEX_W'(k)) begin
               coef_ff[k] <= csr_data[SAMPLE_W-1:0];
            end
         end
      end
   end

   // zero counts as one tap, anything above TAPS saturates
   always_comb begin
      if (tap_count_ff == '0) begin
         eff_tc = TAP_W'(1);
      end else if (32'(tap_count_ff) > TAPS) begin
         eff_tc = TAP_W'(TAPS);
      end else begin
         eff_tc = TAP_W'(tap_count_ff);
      end
   end

   flconv_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .eff_tc    (eff_tc),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .tok_valid (chain_valid[0]),
      .tok_ready (chain_ready[0]),
      .tok       (chain_tok[0])
   );

   for (genvar k = 0; k < TAPS; k++) begin : g_cell
      flconv_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .coef      (coef_ff[k]),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_tok    (chain_tok[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_tok   (chain_tok[k+1])
      );
   end

   assign rsp_valid            = chain_valid[TAPS];
   assign chain_ready[TAPS]    = rsp_ready;
   assign rsp_data.sum_hi      = chain_tok[TAPS].acc[ACC_W-1:SAMPLE_W];
   assign rsp_data.sum_lo      = chain_tok[TAPS].acc[SAMPLE_W-1:0];
   assign rsp_data.last_result = chain_tok[TAPS].last;

endmodule

>>> rtl/core/flconv_checker.sv
// flconv_checker: port-level checks on the convolution block, bound to the top level
// depends on flconv_pkg and full_linear_convolution_128
`timescale 1ns / 1ps

module flconv_checker import flconv_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input req_type                req_data,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input rsp_type                rsp_data,
   input logic                   csr_valid,
   input logic                   csr_ready,
   input logic [CSR_INDEX_W-1:0] csr_index,
   input logic [CSR_DATA_W-1:0]  csr_data
);

   // nothing leaves the row straight after reset
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   // a stalled result is held
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // a waiting request is held
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("stalled request changed or dropped");

   // configuration writes are never back-pressured
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write stalled");

   // register writes carry a known index and value
   a_csr_known: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> !$isunknown({csr_index, csr_data}))
      else $error("register write with unknown index or data");

endmodule

bind full_linear_convolution_128 flconv_checker u_checker (.*);

>>> dv/flconv_check.sv
// flconv_check: watches the request, result and register channels of the convolution block,
// predicts every result and compares it field by field
// depends on flconv_pkg
`timescale 1ns / 1ps

module flconv_check import flconv_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_type                req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_type                rsp_data,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     mismatches,
   output int                     outstanding
);

   logic [TAP_COUNT_W-1:0] tap_count;
   logic [SAMPLE_W-1:0]    coef [TAPS];
   logic [SAMPLE_W-1:0]    history [WIN_D];
   rsp_type                expected_sums [$];

   // zero reads as one tap, anything above TAPS saturates
   function automatic int unsigned taps_in_use(input logic [TAP_COUNT_W-1:0] count);
      if (count == 0) begin
         return 1;
      end
      if (count > TAPS) begin
         return TAPS;
      end
      return count;
   endfunction

   task automatic predict_sum(input logic [SAMPLE_W-1:0] x, input int unsigned tc,
                              input bit mark);
      logic [ACC_W-1:0] acc;
      rsp_type          item;
      acc = ACC_W'(x) * ACC_W'(coef[tc-1]);
      for (int unsigned j = 1; j < tc; j++) begin
         acc += ACC_W'(history[j-1]) * ACC_W'(coef[tc-1-j]);
      end
      item.sum_hi      = acc[ACC_W-1:SAMPLE_W];
      item.sum_lo      = acc[SAMPLE_W-1:0];
      item.last_result = mark;
      expected_sums.push_back(item);
      for (int k = WIN_D - 1; k > 0; k--) begin
         history[k] = history[k-1];
      end
      history[0] = x;
   endtask

   always @(posedge clock) begin
      rsp_type     got;
      rsp_type     want;
      int unsigned tc;
      if (reset) begin
         tap_count = TAP_COUNT_RESET;
         foreach (coef[i]) coef[i] = '0;
         foreach (history[i]) history[i] = '0;
         expected_sums.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (expected_sums.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result transaction, expected none, got %h", $time, got);
            end else begin
               want = expected_sums.pop_front();
               if (got.sum_hi !== want.sum_hi) begin
                  mismatches++;
                  $display("%0t: sum_hi mismatch, expected %h, got %h", $time,
                           want.sum_hi, got.sum_hi);
               end
               if (got.sum_lo !== want.sum_lo) begin
                  mismatches++;
                  $display("%0t: sum_lo mismatch, expected %h, got %h", $time,
                           want.sum_lo, got.sum_lo);
               end
               if (got.last_result !== want.last_result) begin
                  mismatches++;
                  $display("%0t: last_result mismatch, expected %b, got %b", $time,
                           want.last_result, got.last_result);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_TAP_COUNT) begin
               tap_count = csr_data[TAP_COUNT_W-1:0];
            end else if (csr_index >= CSR_COEF_0 && csr_index < CSR_COEF_0 + TAPS) begin
               coef[HIST_IDX_W'(csr_index - CSR_COEF_0)] = csr_data;
            end
         end
         if (req_valid && req_ready) begin
            tc = taps_in_use(tap_count);
            predict_sum(req_data.sample, tc, req_data.last_sample && tc == 1);
            if (req_data.last_sample) begin
               // flush: zeros shift in until the full length is out
               for (int unsigned f = 1; f < tc; f++) begin
                  predict_sum('0, tc, f == tc - 1);
               end
               foreach (history[i]) history[i] = '0;
            end
         end
      end
      outstanding = expected_sums.size();
   end

endmodule

>>> dv/tb_full_linear_convolution_128.sv
// tb_full_linear_convolution_128: stimulus, clock and verdict for the convolution block
// depends on flconv_pkg, full_linear_convolution_128 and the checker in flconv_check
`timescale 1ns / 1ps

module tb_full_linear_convolution_128;
   import flconv_pkg::*;

   localparam int RUN_LIMIT     = 200000;
   localparam int PHASES        = 9;
   localparam int PHASE_SAMPLES = 46;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED  = CSR_INDEX_W'(CSR_COEF_0 + TAPS);
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_TOP = '1;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   req_type                req_data  = '0;
   logic                   rsp_ready = 1'b0;
   logic                   csr_valid = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;
   logic                   req_ready;
   logic                   rsp_valid;
   rsp_type                rsp_data;
   logic                   csr_ready;
   int                     mismatches;
   int                     outstanding;
   bit                     steady = 1'b0;
   logic [SAMPLE_W-1:0]    kernel_words [TAPS];

   full_linear_convolution_128 DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   flconv_check u_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 14);
   end

   function automatic logic [SAMPLE_W-1:0] pick_word();
      int unsigned bit_pos;
      bit_pos = $urandom_range(0, SAMPLE_W - 1);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return SAMPLE_W'($urandom_range(0, 15));
         3: return SAMPLE_W'(1) << bit_pos;
         4: return ~(SAMPLE_W'(1) << bit_pos);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // tap count in the low bits, noise above
   function automatic logic [CSR_DATA_W-1:0] tap_word(input int unsigned count);
      logic [CSR_DATA_W-1:0] w;
      w = {$urandom, $urandom};
      w[TAP_COUNT_W-1:0] = TAP_COUNT_W'(count);
      return w;
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      bit done;
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      done = 1'b0;
      while (!done) begin
         @(posedge clock);
         done = csr_ready;
         @(negedge clock);
      end
   endtask

   task automatic close_writes();
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_kernel(input logic [CSR_DATA_W-1:0] count_word);
      write_reg(CSR_TAP_COUNT, count_word);
      for (int i = 0; i < TAPS; i++) begin
         write_reg(CSR_INDEX_W'(CSR_COEF_0 + i), kernel_words[i]);
      end
      if ($urandom_range(0, 3) == 0) begin
         write_reg(CSR_INDEX_W'($urandom_range(CSR_UNMAPPED, CSR_INDEX_TOP)), pick_word());
      end
      close_writes();
   endtask

   task automatic send(input logic [SAMPLE_W-1:0] sample, input bit last);
      req_type item;
      bit      done;
      while (!steady && $urandom_range(0, 99) < 14) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      item.sample      = sample;
      item.last_sample = last;
      req_valid <= 1'b1;
      req_data  <= item;
      done = 1'b0;
      while (!done) begin
         @(posedge clock);
         done = req_ready;
         @(negedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      repeat (RUN_LIMIT) @(posedge clock);
      $display("FAIL full_linear_convolution_128");
      $finish;
   end

   initial begin
      int unsigned tc;
      int unsigned pick;
      int          sent;
      int          run;
      bit          open_end;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // largest operands everywhere but one zero sample, full kernel
      foreach (kernel_words[i]) kernel_words[i] = '1;
      load_kernel(tap_word(4));
      send('1, 1'b0);
      send('1, 1'b0);
      send('0, 1'b0);
      send('1, 1'b1);
      drain();

      // single tap, each sample marked last gives its own result
      foreach (kernel_words[i]) kernel_words[i] = pick_word();
      kernel_words[0] = '1;
      load_kernel(tap_word(1));
      send('1, 1'b1);
      send(pick_word(), 1'b1);
      drain();

      // zero tap count behaves as one tap
      foreach (kernel_words[i]) kernel_words[i] = pick_word();
      load_kernel(tap_word(0));
      send(pick_word(), 1'b0);
      send(pick_word(), 1'b0);
      send(pick_word(), 1'b1);
      drain();

      // oversized tap count saturates
      foreach (kernel_words[i]) kernel_words[i] = pick_word();
      load_kernel(tap_word(7));
      send('1, 1'b0);
      send(pick_word(), 1'b0);
      send(pick_word(), 1'b0);
      send('1, 1'b1);
      drain();

      // tap count changed part way through a sequence
      foreach (kernel_words[i]) kernel_words[i] = pick_word();
      load_kernel(tap_word(2));
      send(pick_word(), 1'b0);
      send(pick_word(), 1'b0);
      send(pick_word(), 1'b0);
      drain();
      write_reg(CSR_TAP_COUNT, tap_word(4));
      close_writes();
      send(pick_word(), 1'b0);
      send(pick_word(), 1'b1);
      drain();

      // writes to unmapped indexes change nothing
      write_reg(CSR_UNMAPPED, pick_word());
      write_reg(CSR_INDEX_TOP, pick_word());
      close_writes();
      load_kernel(tap_word(3));
      send('1, 1'b1);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         pick = $urandom_range(0, 9);
         if (pick < 8) begin
            tc = pick % 4 + 1;
         end else if (pick == 8) begin
            tc = 0;
         end else begin
            tc = $urandom_range(5, 7);
         end
         foreach (kernel_words[i]) kernel_words[i] = pick_word();
         steady = (p == 4);
         load_kernel(tap_word(tc));
         open_end = ($urandom_range(0, 2) == 0);
         sent = 0;
         while (sent < PHASE_SAMPLES) begin
            run = $urandom_range(1, 10);
            for (int i = 0; i < run && sent < PHASE_SAMPLES; i++) begin
               sent++;
               send(pick_word(), (i == run - 1 || sent == PHASE_SAMPLES) &&
                                 !(open_end && sent == PHASE_SAMPLES));
            end
         end
         // sender holds off until every result is back
         drain();
      end
      steady = 1'b0;

      drain();
      repeat (2 * TAPS + 4) @(negedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("PASS full_linear_convolution_128");
      end else begin
         $display("FAIL full_linear_convolution_128");
      end
      $finish;
   end

endmodule
